>>> hdl/assert_macros.svh
// assertion macros for the sorted priority queue unit
// no dependencies; included by the modules that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SSPQ_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("sspq assertion failed");
`define SSPQ_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("sspq assertion failed");
`else
`define SSPQ_ASSERT(label, clk, rst_n, prop)
`define SSPQ_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

>>> hdl/sspq_pkg.sv
// shared types, codes and default sizes of the sorted priority queue unit
// no dependencies
`default_nettype none
package sspq_pkg;

    localparam int DEF_DEPTH      = 16;
    localparam int DEF_LEVEL_BITS = 8;
    localparam int DEF_TAG_BITS   = 16;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    typedef enum logic [1:0] {
        STS_DONE      = 2'd0,
        STS_FULL_DROP = 2'd1,
        STS_EMPTY_IGN = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_HOLD
    } t_state;

    typedef struct packed {
        logic    do_enq;
        logic    do_deq;
        logic    load;
        t_status status;
    } t_dp_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_dp_stat;

endpackage
`default_nettype wire

>>> hdl/sspq_ctrl.sv
// controller: request handshake, result holding and command decode
// depends on sspq_pkg
`default_nettype none
module sspq_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_req_valid,
    input  wire               i_op,
    output logic              o_req_ready,
    output logic              o_res_valid,
    input  wire               i_res_ready,
    input  sspq_pkg::t_dp_stat i_stat,
    output sspq_pkg::t_dp_cmd  o_cmd
);
    import sspq_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign w_accept = i_req_valid && o_req_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_HOLD;
            end
            S_HOLD: begin
                if (!w_accept && i_res_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_req_ready = 1'b0;
        o_res_valid = 1'b0;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                o_req_ready = i_rst_n;
            end
            S_HOLD: begin
                o_req_ready = i_res_ready;
                o_res_valid = 1'b1;
            end
            default: begin
                o_req_ready = 1'b0;
            end
        endcase
        if (w_accept) begin
            o_cmd.load = 1'b1;
            if (i_op == OP_ENQ) begin
                if (i_stat.full) o_cmd.status = STS_FULL_DROP;
                else             o_cmd.do_enq = 1'b1;
            end else begin
                if (i_stat.empty) o_cmd.status = STS_EMPTY_IGN;
                else              o_cmd.do_deq = 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

>>> hdl/sspq_datapath.sv
// datapath: row of sorted slots with per-slot compare and shift, count and status
// depends on sspq_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module sspq_datapath #(
    parameter int DEPTH      = sspq_pkg::DEF_DEPTH,
    parameter int LEVEL_BITS = sspq_pkg::DEF_LEVEL_BITS,
    parameter int TAG_BITS   = sspq_pkg::DEF_TAG_BITS,
    parameter int CNT_W      = $clog2(DEPTH + 1)
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  sspq_pkg::t_dp_cmd     i_cmd,
    output sspq_pkg::t_dp_stat    o_stat,
    input  wire  [LEVEL_BITS-1:0] i_level,
    input  wire  [TAG_BITS-1:0]   i_tag,
    output logic                  o_head_valid,
    output logic [LEVEL_BITS-1:0] o_head_level,
    output logic [TAG_BITS-1:0]   o_head_tag,
    output logic [CNT_W-1:0]      o_count,
    output sspq_pkg::t_status     o_status
);
    import sspq_pkg::*;

    logic [LEVEL_BITS-1:0] r_lvl [DEPTH];
    logic [TAG_BITS-1:0]   r_tag [DEPTH];
    logic [CNT_W-1:0]      r_count;
    t_status               r_status;

    logic [DEPTH-1:0]      w_le;
    logic [DEPTH-1:0]      w_prev_le;
    logic [LEVEL_BITS-1:0] w_prev_lvl [DEPTH];
    logic [TAG_BITS-1:0]   w_prev_tag [DEPTH];
    logic [LEVEL_BITS-1:0] w_next_lvl [DEPTH];
    logic [TAG_BITS-1:0]   w_next_tag [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_slot
        assign w_le[g] = (CNT_W'(g) < r_count) && (r_lvl[g] <= i_level);

        if (g == 0) begin : g_first
            assign w_prev_le[g]  = 1'b1;
            assign w_prev_lvl[g] = i_level;
            assign w_prev_tag[g] = i_tag;
        end else begin : g_inner
            assign w_prev_le[g]  = w_le[g-1];
            assign w_prev_lvl[g] = r_lvl[g-1];
            assign w_prev_tag[g] = r_tag[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_next_lvl[g] = r_lvl[g];
            assign w_next_tag[g] = r_tag[g];
        end else begin : g_body
            assign w_next_lvl[g] = r_lvl[g+1];
            assign w_next_tag[g] = r_tag[g+1];
        end

        // insert where the run of lower-or-equal levels ends, shift the rest up; on dequeue shift every slot down
        always_ff @(posedge i_clk) begin
            if (i_cmd.do_enq && !w_le[g]) begin
                if (w_prev_le[g]) begin
                    r_lvl[g] <= i_level;
                    r_tag[g] <= i_tag;
                end else begin
                    r_lvl[g] <= w_prev_lvl[g];
                    r_tag[g] <= w_prev_tag[g];
                end
            end else if (i_cmd.do_deq) begin
                r_lvl[g] <= w_next_lvl[g];
                r_tag[g] <= w_next_tag[g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_status <= STS_DONE;
        end else begin
            if (i_cmd.do_enq)      r_count <= r_count + CNT_W'(1);
            else if (i_cmd.do_deq) r_count <= r_count - CNT_W'(1);
            if (i_cmd.load) r_status <= i_cmd.status;
        end
    end

    assign o_stat.full   = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty  = (r_count == '0);
    assign o_head_valid  = (r_count != '0);
    assign o_head_level  = o_head_valid ? r_lvl[0] : '0;
    assign o_head_tag    = o_head_valid ? r_tag[0] : '0;
    assign o_count       = r_count;
    assign o_status      = r_status;

    `SSPQ_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(DEPTH))
    `SSPQ_ASSERT(a_enq_count, i_clk, i_rst_n,
        i_cmd.do_enq |=> r_count == $past(r_count) + CNT_W'(1))
    `SSPQ_ASSERT(a_deq_count, i_clk, i_rst_n,
        i_cmd.do_deq |=> r_count == $past(r_count) - CNT_W'(1))
    `SSPQ_ASSERT(a_head_sorted, i_clk, i_rst_n,
        (r_count >= CNT_W'(2)) |-> (r_lvl[0] <= r_lvl[1]))
    `SSPQ_ASSERT(a_dropped_code, i_clk, i_rst_n,
        (i_cmd.load && !i_cmd.do_enq && !i_cmd.do_deq) |=> r_status != STS_DONE)

endmodule
`default_nettype wire

>>> hdl/stable_sorted_priority_queue_unit.sv
// top level of the stable sorted priority queue: stream ports, controller, datapath
// depends on sspq_pkg, sspq_ctrl, sspq_datapath
//
// channel  dir  handshake             tuser   tdata (lowest bits first)
// s        in   i_s_tvalid/o_s_tready op      priority_level, entry_tag
// m        out  o_m_tvalid/i_m_tready status  head_valid, head_level, head_tag, entry_count
//
// each request is applied to the slot row in the cycle it is accepted
// the result is held in the output stage from the next cycle until taken
// a new request is taken in the same cycle the held result is taken
// reset clears the entry count and the output stage; slot contents need no clearing
// a stall on the m side holds off the s side
`default_nettype none
module stable_sorted_priority_queue_unit #(
    parameter int DEPTH      = sspq_pkg::DEF_DEPTH,
    parameter int LEVEL_BITS = sspq_pkg::DEF_LEVEL_BITS,
    parameter int TAG_BITS   = sspq_pkg::DEF_TAG_BITS,
    parameter int CNT_W      = $clog2(DEPTH + 1),
    parameter int IN_W       = ((LEVEL_BITS + TAG_BITS + 7) / 8) * 8,
    parameter int OUT_W      = ((1 + LEVEL_BITS + TAG_BITS + CNT_W + 7) / 8) * 8
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_s_tvalid,
    output logic             o_s_tready,
    input  wire  [IN_W-1:0]  i_s_tdata,   // priority_level, entry_tag
    input  wire              i_s_tuser,   // op
    output logic             o_m_tvalid,
    input  wire              i_m_tready,
    output logic [OUT_W-1:0] o_m_tdata,   // head_valid, head_level, head_tag, entry_count
    output logic [1:0]       o_m_tuser    // status
);
    import sspq_pkg::*;

    t_dp_cmd               w_cmd;
    t_dp_stat              w_stat;
    logic                  w_head_valid;
    logic [LEVEL_BITS-1:0] w_head_level;
    logic [TAG_BITS-1:0]   w_head_tag;
    logic [CNT_W-1:0]      w_count;
    t_status               w_status;

    sspq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_tvalid),
        .i_op        (i_s_tuser),
        .o_req_ready (o_s_tready),
        .o_res_valid (o_m_tvalid),
        .i_res_ready (i_m_tready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    sspq_datapath #(
        .DEPTH      (DEPTH),
        .LEVEL_BITS (LEVEL_BITS),
        .TAG_BITS   (TAG_BITS),
        .CNT_W      (CNT_W)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_level      (i_s_tdata[LEVEL_BITS-1:0]),
        .i_tag        (i_s_tdata[LEVEL_BITS+TAG_BITS-1:LEVEL_BITS]),
        .o_head_valid (w_head_valid),
        .o_head_level (w_head_level),
        .o_head_tag   (w_head_tag),
        .o_count      (w_count),
        .o_status     (w_status)
    );

    assign o_m_tdata = OUT_W'({w_count, w_head_tag, w_head_level, w_head_valid});
    assign o_m_tuser = w_status;

endmodule
`default_nettype wire

>>> verif/sspq_scoreboard_pkg.sv
// scoreboard for the sorted priority queue unit: predicts the head report of every request
// depends on sspq_pkg
`default_nettype none
package sspq_scoreboard_pkg;

    import sspq_pkg::*;

    localparam int SLOTS  = DEF_DEPTH;
    localparam int LVL_W  = DEF_LEVEL_BITS;
    localparam int TAG_W  = DEF_TAG_BITS;
    localparam int CNT_W  = $clog2(DEF_DEPTH + 1);

    typedef struct packed {
        logic             head_valid;
        logic [LVL_W-1:0] head_level;
        logic [TAG_W-1:0] head_tag;
        logic [CNT_W-1:0] entry_count;
        t_status          status;
    } t_head_report;

    class queue_scoreboard;
        logic [LVL_W-1:0] level_row[SLOTS];
        logic [TAG_W-1:0] tag_row[SLOTS];
        int unsigned      fill;
        t_head_report     expected_heads[$];
        int unsigned      mismatches;
        int unsigned      checked;

        function new();
            fill       = 0;
            mismatches = 0;
            checked    = 0;
        endfunction

        function int unsigned pending();
            return expected_heads.size();
        endfunction

        function void note_request(logic op, logic [LVL_W-1:0] lvl, logic [TAG_W-1:0] tag);
            t_head_report rep;
            int unsigned  pos;
            rep.status = STS_DONE;
            if (op == OP_ENQ) begin
                if (fill >= SLOTS) begin
                    rep.status = STS_FULL_DROP;
                end else begin
                    pos = 0;
                    while (pos < fill && level_row[pos] <= lvl) pos++;
                    for (int i = fill; i > pos; i--) begin
                        level_row[i] = level_row[i-1];
                        tag_row[i]   = tag_row[i-1];
                    end
                    level_row[pos] = lvl;
                    tag_row[pos]   = tag;
                    fill++;
                end
            end else begin
                if (fill == 0) begin
                    rep.status = STS_EMPTY_IGN;
                end else begin
                    for (int i = 0; i + 1 < fill; i++) begin
                        level_row[i] = level_row[i+1];
                        tag_row[i]   = tag_row[i+1];
                    end
                    fill--;
                end
            end
            rep.head_valid  = (fill > 0);
            rep.head_level  = (fill > 0) ? level_row[0] : '0;
            rep.head_tag    = (fill > 0) ? tag_row[0] : '0;
            rep.entry_count = CNT_W'(fill);
            expected_heads.push_back(rep);
        endfunction

        function void check_result(t_head_report got);
            t_head_report want;
            checked++;
            if (expected_heads.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d arrived with no request pending: valid=%0d level=%0d tag=%h count=%0d status=%0d",
                             checked, got.head_valid, got.head_level, got.head_tag,
                             got.entry_count, got.status);
                return;
            end
            want = expected_heads.pop_front();
            if (got.head_valid !== want.head_valid || got.head_level !== want.head_level ||
                got.head_tag !== want.head_tag || got.entry_count !== want.entry_count ||
                got.status !== want.status) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d wrong: expected valid=%0d level=%0d tag=%h count=%0d status=%0d, got valid=%0d level=%0d tag=%h count=%0d status=%0d",
                             checked, want.head_valid, want.head_level, want.head_tag,
                             want.entry_count, want.status, got.head_valid, got.head_level,
                             got.head_tag, got.entry_count, got.status);
            end
        endfunction
    endclass

endpackage
`default_nettype wire

>>> verif/testbench.sv
// stream-level test of the stable sorted priority queue unit: directed then random requests
// depends on sspq_pkg, sspq_scoreboard_pkg and the unit itself
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sspq_pkg::*;
    import sspq_scoreboard_pkg::*;

    localparam int IN_W  = ((LVL_W + TAG_W + 7) / 8) * 8;
    localparam int OUT_W = ((1 + LVL_W + TAG_W + CNT_W + 7) / 8) * 8;
    localparam int RANDOM_REQUESTS = 650;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_s_tvalid;
    logic             o_s_tready;
    logic [IN_W-1:0]  i_s_tdata;   // priority_level, entry_tag
    logic             i_s_tuser;   // op
    logic             o_m_tvalid;
    logic             i_m_tready;
    logic [OUT_W-1:0] o_m_tdata;   // head_valid, head_level, head_tag, entry_count
    logic [1:0]       o_m_tuser;   // status

    queue_scoreboard sb;
    bit              steady;
    int unsigned     stall_left;

    stable_sorted_priority_queue_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    // result side stalls
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_m_tready <= 1'b0;
        end else begin
            stall_left = pick_gap();
            if (stall_left > 0) begin
                stall_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready)
                sb.check_result({o_m_tdata[0], o_m_tdata[LVL_W:1],
                                 o_m_tdata[LVL_W+TAG_W:LVL_W+1],
                                 o_m_tdata[LVL_W+TAG_W+CNT_W:LVL_W+TAG_W+1],
                                 t_status'(o_m_tuser)});
            if (i_s_tvalid && o_s_tready)
                sb.note_request(i_s_tuser, i_s_tdata[LVL_W-1:0],
                                i_s_tdata[LVL_W+TAG_W-1:LVL_W]);
        end
    end

    task automatic send_request(logic op, logic [LVL_W-1:0] lvl, logic [TAG_W-1:0] tag);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= IN_W'({tag, lvl});
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    function automatic logic [LVL_W-1:0] pick_level(int unsigned spread);
        case (spread)
            0: return LVL_W'($urandom_range(0, 3));
            1: return ($urandom_range(0, 1) == 0) ? '0 : '1;
            default: return LVL_W'($urandom);
        endcase
    endfunction

    initial begin
        int unsigned sent;
        int unsigned enq_pct;
        int unsigned spread;
        int unsigned seg_len;
        sb         = new();
        steady     = 1'b0;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tuser  <= OP_ENQ;
        i_s_tdata  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty, ties, extremes, then fill past full
        send_request(OP_DEQ, '1, '1);
        send_request(OP_ENQ, 8'd128, 16'h0001);
        send_request(OP_ENQ, 8'd128, 16'h0002);
        send_request(OP_ENQ, '1, '1);
        send_request(OP_ENQ, '0, '0);
        send_request(OP_ENQ, 8'd128, 16'h0003);
        send_request(OP_ENQ, '0, 16'h8000);
        send_request(OP_DEQ, 8'h5a, 16'ha5a5);
        for (int k = 0; k < 11; k++)
            send_request(OP_ENQ, (k % 3 == 0) ? 8'hff : LVL_W'($urandom), TAG_W'($urandom));
        send_request(OP_ENQ, '0, '1);
        send_request(OP_DEQ, '0, '0);
        send_request(OP_ENQ, '1, 16'h7fff);

        sent = 0;
        while (sent < RANDOM_REQUESTS) begin
            case ($urandom_range(0, 4))
                0: enq_pct = 10;
                1: enq_pct = 30;
                2: enq_pct = 50;
                3: enq_pct = 70;
                default: enq_pct = 90;
            endcase
            spread  = $urandom_range(0, 2);
            steady  = ($urandom_range(0, 3) == 0);
            seg_len = $urandom_range(20, 60);
            repeat (seg_len) begin
                if (sent < RANDOM_REQUESTS) begin
                    if ($urandom_range(1, 100) <= enq_pct)
                        send_request(OP_ENQ, pick_level(spread), TAG_W'($urandom));
                    else
                        send_request(OP_DEQ, LVL_W'($urandom), TAG_W'($urandom));
                    sent++;
                end
            end
        end
        steady = 1'b0;
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
`default_nettype wire

>>> sim.f
+incdir+hdl
hdl/sspq_pkg.sv
hdl/sspq_ctrl.sv
hdl/sspq_datapath.sv
hdl/stable_sorted_priority_queue_unit.sv
verif/sspq_scoreboard_pkg.sv
verif/testbench.sv
